@@ rtl/core/glob_allowlist_matcher_assert.svh @@
// Assertion macros used by the allowlist matcher RTL.
`ifndef GLOB_ALLOWLIST_MATCHER_ASSERT_SVH
`define GLOB_ALLOWLIST_MATCHER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define GAM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allowlist matcher check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define GAM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allowlist matcher check failed");

`endif

@@ rtl/core/gam_pkg.sv @@
// Shared types and constants of the glob allowlist matcher.
`default_nettype none

package gam_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 16;
    localparam int LEN_W                 = 5;
    localparam int IN_USE_W              = 2;
    localparam int CHARS_W               = 64;
    localparam int CFG_IDX_W             = 3;

    localparam logic [7:0] STAR_BYTE     = 8'h2A;
    localparam logic [7:0] QUESTION_BYTE = 8'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_FIRST  = 3'd0,
        CFG_A_LAST   = 3'd1,
        CFG_A_LENGTH = 3'd2,
        CFG_B_FIRST  = 3'd3,
        CFG_B_LAST   = 3'd4,
        CFG_B_LENGTH = 3'd5,
        CFG_IN_USE   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
        logic       is_empty;
    } t_in_item;

    typedef struct packed {
        logic allowed;
        logic match_a;
        logic match_b;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CHARS_W-1:0]   wr_data;
    } t_cfg_write;

    typedef struct packed {
        logic [CHARS_W-1:0] first_chars;
        logic [CHARS_W-1:0] last_chars;
        logic [LEN_W-1:0]   length;
    } t_pattern;

    typedef struct packed {
        t_pattern              pat_a;
        t_pattern              pat_b;
        logic [IN_USE_W-1:0]   in_use;
    } t_cfg_state;

endpackage

`default_nettype wire

@@ rtl/core/gam_ifs.sv @@
// Valid/ready channel interfaces of the glob allowlist matcher.
`default_nettype none

interface gam_in_if;
    import gam_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gam_out_if;
    import gam_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gam_cfg_if;
    import gam_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_write data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gam_cfg_regs.sv @@
// Configuration register file holding both patterns and the in-use count.
`default_nettype none

module gam_cfg_regs (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    gam_cfg_if.sink             i_cfg,
    output gam_pkg::t_cfg_state o_cfg
);
    import gam_pkg::*;

    t_cfg_state r_cfg;
    t_cfg_state n_cfg;
    logic       wr_fire;

    assign i_cfg.ready = 1'b1;
    assign wr_fire     = i_cfg.valid & i_cfg.ready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_fire) begin
            unique case (t_cfg_idx'(i_cfg.data.reg_index))
                CFG_A_FIRST:  n_cfg.pat_a.first_chars = i_cfg.data.wr_data;
                CFG_A_LAST:   n_cfg.pat_a.last_chars  = i_cfg.data.wr_data;
                CFG_A_LENGTH: n_cfg.pat_a.length      = i_cfg.data.wr_data[LEN_W-1:0];
                CFG_B_FIRST:  n_cfg.pat_b.first_chars = i_cfg.data.wr_data;
                CFG_B_LAST:   n_cfg.pat_b.last_chars  = i_cfg.data.wr_data;
                CFG_B_LENGTH: n_cfg.pat_b.length      = i_cfg.data.wr_data[LEN_W-1:0];
                CFG_IN_USE:   n_cfg.in_use            = i_cfg.data.wr_data[IN_USE_W-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/core/gam_nfa.sv @@
// Bit-parallel NFA for one glob pattern: active-position register and byte step.
`default_nettype none

module gam_nfa #(
    parameter int MAX_PATTERN_BYTES = gam_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire gam_pkg::t_pattern i_pattern,
    input  wire  [7:0]             i_byte,
    input  wire                    i_step,
    input  wire                    i_end,
    input  wire                    i_empty,
    output logic                   o_match
);
    import gam_pkg::*;

    localparam int SET_W   = MAX_PATTERN_BYTES + 1;
    localparam int POS_W   = $clog2(SET_W);
    localparam int NSTEP   = $clog2(SET_W);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

    // Positions reachable across runs of stars: a carry-style prefix over the
    // star mask, doubling the span at each level.
    function automatic logic [SET_W-1:0] star_close(input logic [SET_W-1:0] set,
                                                    input logic [SET_W-1:0] star);
        logic [SET_W-1:0] g;
        logic [SET_W-1:0] p;
        g = set;
        p = star;
        for (int k = 0; k < NSTEP; k++) begin
            g = g | ((g & p) << (1 << k));
            p = p & (p >> (1 << k));
        end
        return g;
    endfunction

    logic [SET_W-1:0]       r_set;
    logic [SET_W-1:0]       n_set;
    logic [2*CHARS_W-1:0]   chars;
    logic [LEN_W-1:0]       len_eff;
    logic [POS_W-1:0]       len_pos;
    logic [SET_W-1:0]       star_m;
    logic [SET_W-1:0]       move_m;
    logic [SET_W-1:0]       cur_c;
    logic [SET_W-1:0]       adv_set;
    logic [SET_W-1:0]       eval_set;
    logic [SET_W-1:0]       eval_c;

    assign chars   = {i_pattern.last_chars, i_pattern.first_chars};
    assign len_eff = (i_pattern.length > MAX_LEN) ? MAX_LEN : i_pattern.length;
    assign len_pos = len_eff[POS_W-1:0];

    always_comb begin
        star_m = '0;
        move_m = '0;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            if (LEN_W'(i) < len_eff) begin
                star_m[i] = (chars[8*i +: 8] == STAR_BYTE);
                move_m[i] = (chars[8*i +: 8] != STAR_BYTE)
                          & ((chars[8*i +: 8] == QUESTION_BYTE) | (chars[8*i +: 8] == i_byte));
            end
        end
    end

    // A star position keeps itself; a literal or '?' that fits moves one on.
    assign cur_c    = star_close(r_set, star_m);
    assign adv_set  = star_close((cur_c & star_m) | ((cur_c & move_m) << 1), star_m);
    assign eval_set = i_empty ? r_set : adv_set;
    assign eval_c   = star_close(eval_set, star_m);
    assign o_match  = eval_c[len_pos];

    always_comb begin
        n_set = r_set;
        if (i_end) begin
            n_set = SET_W'(1);
        end else if (i_step) begin
            n_set = adv_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set <= SET_W'(1);
        end else begin
            r_set <= n_set;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/glob_allowlist_matcher.sv @@
// Top level of the glob allowlist matcher: input register, two NFAs, result register.
//
//  channel   dir   payload                            transfer when
//  i_text    in    text_byte, is_last, is_empty       i_text.valid & i_text.ready
//  o_result  out   allowed, match_a, match_b          o_result.valid & o_result.ready
//  i_cfg     in    reg_index, wr_data                 i_cfg.valid (ready is tied high)
//
// One text byte per cycle unless a command end waits: a byte is held in the input
// register; the combinational NFA step and match decision feed the result register.
// A byte that ends a command needs a free result register; other bytes never wait.
// Synchronous active-low reset clears both active sets to the start position,
// empties both registers and clears all configuration to zero.
`default_nettype none

module glob_allowlist_matcher #(
    parameter int MAX_PATTERN_BYTES = gam_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    gam_in_if.sink     i_text,
    gam_out_if.source  o_result,
    gam_cfg_if.sink    i_cfg
);
    import gam_pkg::*;

    t_cfg_state cfg;
    logic       r_in_valid;
    logic       n_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    logic       n_out_valid;
    t_out_item  r_out;
    logic       ends;
    logic       out_free;
    logic       fire;
    logic       step;
    logic       end_cmd;
    logic       raw_a;
    logic       raw_b;
    logic       ma;
    logic       mb;

    gam_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign ends     = r_in.is_empty | r_in.is_last;
    assign out_free = ~r_out_valid | o_result.ready;
    assign fire     = r_in_valid & (~ends | out_free);
    assign step     = fire & ~r_in.is_empty;
    assign end_cmd  = fire & ends;

    gam_nfa #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_nfa_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pattern (cfg.pat_a),
        .i_byte    (r_in.text_byte),
        .i_step    (step),
        .i_end     (end_cmd),
        .i_empty   (r_in.is_empty),
        .o_match   (raw_a)
    );

    gam_nfa #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_nfa_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pattern (cfg.pat_b),
        .i_byte    (r_in.text_byte),
        .i_step    (step),
        .i_end     (end_cmd),
        .i_empty   (r_in.is_empty),
        .o_match   (raw_b)
    );

    // An in-use count of three behaves as two.
    assign ma = raw_a & (|cfg.in_use);
    assign mb = raw_b & cfg.in_use[1];

    assign i_text.ready    = ~r_in_valid | fire;
    assign o_result.valid  = r_out_valid;
    assign o_result.data   = r_out;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_text.valid & i_text.ready) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (end_cmd) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid & i_text.ready) begin
            r_in <= i_text.data;
        end
        if (end_cmd) begin
            r_out.allowed <= ma | mb;
            r_out.match_a <= ma;
            r_out.match_b <= mb;
        end
    end

`include "glob_allowlist_matcher_assert.svh"

    `GAM_ASSERT_NEXT(a_end_gives_result, end_cmd, r_out_valid)
    `GAM_ASSERT_NEXT(a_no_spurious_result, !r_out_valid && !end_cmd, !r_out_valid)
    `GAM_ASSERT_SAME(a_allowed_is_or, r_out_valid, r_out.allowed == (r_out.match_a | r_out.match_b))
    `GAM_ASSERT_SAME(a_empty_input_ready, !r_in_valid, i_text.ready)

endmodule

`default_nettype wire

@@ test/tb_glob_allowlist_matcher.sv @@
// Testbench for the glob allowlist matcher: directed and random commands checked by a predictor.
module tb_glob_allowlist_matcher;
    import gam_pkg::*;

    localparam int NB         = MAX_PATTERN_BYTES_DEF;
    localparam int ITEM_GOAL  = 1150;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [NB:0] t_pos_set;
    typedef logic [7:0]  t_bytes[$];

    // Tracks both patterns as position sets and keeps the verdicts still owed by the block.
    class allowlist_scoreboard;
        t_pattern   pat_a;
        t_pattern   pat_b;
        logic [1:0] in_use;
        t_pos_set   live_a;
        t_pos_set   live_b;
        t_out_item  verdicts[$];
        int         mismatches;

        function new();
            pat_a      = '0;
            pat_b      = '0;
            in_use     = '0;
            live_a     = t_pos_set'(1);
            live_b     = t_pos_set'(1);
            mismatches = 0;
        endfunction

        static function int eff_len(t_pattern p);
            return (p.length > NB) ? NB : int'(p.length);
        endfunction

        static function logic [7:0] pattern_char(t_pattern p, int i);
            if (i < 8) return p.first_chars[8*i +: 8];
            return p.last_chars[8*(i-8) +: 8];
        endfunction

        // A star may stand for an empty run, so activity passes straight through it.
        static function t_pos_set close_stars(t_pattern p, t_pos_set s);
            int n;
            n = eff_len(p);
            for (int i = 0; i < n; i++) begin
                if (s[i] && pattern_char(p, i) == STAR_BYTE) s[i+1] = 1'b1;
            end
            return s;
        endfunction

        static function t_pos_set step(t_pattern p, t_pos_set s, logic [7:0] c);
            t_pos_set   nxt;
            logic [7:0] b;
            int         n;
            n   = eff_len(p);
            nxt = '0;
            s   = close_stars(p, s);
            for (int i = 0; i < n; i++) begin
                if (s[i]) begin
                    b = pattern_char(p, i);
                    if (b == STAR_BYTE) nxt[i] = 1'b1;
                    else if (b == QUESTION_BYTE || b == c) nxt[i+1] = 1'b1;
                end
            end
            return close_stars(p, nxt);
        endfunction

        static function logic accepts(t_pattern p, t_pos_set s);
            t_pos_set c;
            c = close_stars(p, s);
            return c[eff_len(p)];
        endfunction

        function void apply_write(t_cfg_idx idx, logic [63:0] value);
            case (idx)
                CFG_A_FIRST:  pat_a.first_chars = value;
                CFG_A_LAST:   pat_a.last_chars  = value;
                CFG_A_LENGTH: pat_a.length      = value[LEN_W-1:0];
                CFG_B_FIRST:  pat_b.first_chars = value;
                CFG_B_LAST:   pat_b.last_chars  = value;
                CFG_B_LENGTH: pat_b.length      = value[LEN_W-1:0];
                CFG_IN_USE:   in_use            = value[IN_USE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(t_in_item it);
            t_out_item v;
            int        used;
            if (!it.is_empty) begin
                live_a = step(pat_a, live_a, it.text_byte);
                live_b = step(pat_b, live_b, it.text_byte);
                if (!it.is_last) return;
            end
            used      = (in_use > 2) ? 2 : int'(in_use);
            v.match_a = (used >= 1) && accepts(pat_a, live_a);
            v.match_b = (used >= 2) && accepts(pat_b, live_b);
            v.allowed = v.match_a | v.match_b;
            verdicts = {verdicts, v};
            live_a = t_pos_set'(1);
            live_b = t_pos_set'(1);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result with none outstanding: allowed=%0b a=%0b b=%0b",
                             $time, got.allowed, got.match_a, got.match_b);
                return;
            end
            want = verdicts.pop_front();
            if (got.allowed !== want.allowed || got.match_a !== want.match_a ||
                got.match_b !== want.match_b) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] verdict mismatch: expected allowed=%0b a=%0b b=%0b, got %0b %0b %0b",
                             $time, want.allowed, want.match_a, want.match_b,
                             got.allowed, got.match_a, got.match_b);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    gam_in_if  text_if ();
    gam_out_if result_if ();
    gam_cfg_if cfg_if ();

    glob_allowlist_matcher dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_text   (text_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    allowlist_scoreboard sb;
    int       cycles;
    int       items_sent;
    int       hold_len;
    bit       tx_quiet;
    bit       rx_quiet;
    t_pattern cur_a;
    t_pattern cur_b;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Every transfer is seen here; the input is noted before any verdict of the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (text_if.valid && text_if.ready) sb.note_input(text_if.data);
            if (result_if.valid && result_if.ready) sb.check_result(result_if.data);
            if (cfg_if.valid && cfg_if.ready)
                sb.apply_write(t_cfg_idx'(cfg_if.data.reg_index), cfg_if.data.wr_data);
        end
    end

    // Result side: random stalls, plus one long hold-off requested through hold_len.
    initial begin
        int stall_cnt;
        int hold_cnt;
        int r;
        logic rdy;
        stall_cnt       = 0;
        hold_cnt        = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                hold_cnt = hold_len;
                hold_len = 0;
            end
            if (!i_rst_n) begin
                rdy = 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                rdy = 1'b0;
            end else if (rx_quiet) begin
                rdy = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    rdy = 1'b1;
                end else begin
                    stall_cnt = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                    rdy = 1'b0;
                end
            end
            result_if.ready <= rdy;
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic text_idle(int n);
        logic [9:0] noise;
        repeat (n) begin
            @(negedge i_clk);
            noise = 10'($urandom);
            text_if.valid <= 1'b0;
            text_if.data  <= noise;
        end
    endtask

    task automatic send_item(logic [7:0] b, logic last, logic empty);
        int gap;
        @(negedge i_clk);
        text_if.valid <= 1'b1;
        text_if.data  <= '{text_byte: b, is_last: last, is_empty: empty};
        do @(posedge i_clk); while (!text_if.ready);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) text_idle(gap);
    endtask

    // A command of no bytes, or a cut-short one, ends with an empty-marked transfer.
    task automatic send_command(t_bytes cmd, bit cut_short);
        for (int i = 0; i < cmd.size(); i++)
            send_item(cmd[i], (i == cmd.size() - 1) && !cut_short, 1'b0);
        if (cmd.size() == 0 || cut_short)
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [63:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{reg_index: idx, wr_data: value};
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_pattern(bit second, t_pattern p);
        if (second) begin
            write_reg(CFG_B_FIRST, p.first_chars);
            write_reg(CFG_B_LAST, p.last_chars);
            write_reg(CFG_B_LENGTH, 64'(p.length));
            cur_b = p;
        end else begin
            write_reg(CFG_A_FIRST, p.first_chars);
            write_reg(CFG_A_LAST, p.last_chars);
            write_reg(CFG_A_LENGTH, 64'(p.length));
            cur_a = p;
        end
    endtask

    // Configuration only changes once every owed verdict is in and the pipeline is empty.
    task automatic settle();
        text_idle(1);
        while (sb.verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_pattern pattern_of(string s, logic [LEN_W-1:0] len);
        t_pattern p;
        p.first_chars = '0;
        p.last_chars  = '0;
        p.length      = len;
        for (int i = 0; i < s.len() && i < 16; i++) begin
            if (i < 8) p.first_chars[8*i +: 8] = s[i];
            else p.last_chars[8*(i-8) +: 8] = s[i];
        end
        return p;
    endfunction

    function automatic t_bytes bytes_of(string s);
        t_bytes q;
        for (int i = 0; i < s.len(); i++) q = {q, s[i]};
        return q;
    endfunction

    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 99) < 85) return 8'h61 + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] glob_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 8'h61 + 8'($urandom_range(0, 2));
        if (r < 65) return STAR_BYTE;
        if (r < 85) return QUESTION_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_pattern random_pattern();
        t_pattern p;
        int       r;
        for (int i = 0; i < 8; i++) begin
            p.first_chars[8*i +: 8] = glob_char();
            p.last_chars[8*i +: 8]  = glob_char();
        end
        r = $urandom_range(0, 99);
        if (r < 4) p.first_chars = '1;
        else if (r < 8) p.last_chars = '0;
        r = $urandom_range(0, 99);
        if (r < 10) p.length = 5'($urandom_range(17, 31));
        else if (r < 20) p.length = 5'(NB);
        else if (r < 28) p.length = 5'd0;
        else p.length = 5'($urandom_range(1, 8));
        return p;
    endfunction

    // Builds a command that the pattern should accept, then optionally spoils one byte.
    function automatic t_bytes text_for(t_pattern p, bit spoil);
        t_bytes     q;
        logic [7:0] b;
        int         n;
        n = allowlist_scoreboard::eff_len(p);
        for (int i = 0; i < n; i++) begin
            b = allowlist_scoreboard::pattern_char(p, i);
            if (b == STAR_BYTE) repeat ($urandom_range(0, 3)) q = {q, text_char()};
            else if (b == QUESTION_BYTE) q = {q, 8'($urandom_range(0, 255))};
            else q = {q, b};
        end
        if (spoil) begin
            if (q.size() > 0 && $urandom_range(0, 2) != 0) q[$urandom_range(0, q.size() - 1)] = text_char();
            else if (q.size() > 0 && $urandom_range(0, 1) != 0) void'(q.pop_back());
            else q = {q, text_char()};
        end
        return q;
    endfunction

    task automatic random_command();
        t_bytes   q;
        t_pattern p;
        int       r;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 1) ? cur_b : cur_a;
        if (r < 65) begin
            send_command(text_for(p, 1'b0), 1'b0);
        end else if (r < 77) begin
            send_command(text_for(p, 1'b1), 1'b0);
        end else if (r < 87) begin
            repeat ($urandom_range(1, 10)) q = {q, 8'($urandom_range(0, 255))};
            send_command(q, 1'b0);
        end else if (r < 93) begin
            send_command(q, 1'b0);
        end else begin
            send_command(text_for(p, 1'b0), 1'b1);
        end
    endtask

    task automatic random_settings();
        int r;
        write_pattern(1'b0, random_pattern());
        write_pattern(1'b1, random_pattern());
        r = $urandom_range(0, 99);
        if (r < 15) write_reg(CFG_IN_USE, 64'd0);
        else if (r < 35) write_reg(CFG_IN_USE, 64'd1);
        else if (r < 85) write_reg(CFG_IN_USE, 64'd2);
        else write_reg(CFG_IN_USE, 64'd3);
    endtask

    initial begin
        int phase;
        sb            = new();
        cycles        = 0;
        items_sent    = 0;
        hold_len      = 0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        cur_a         = '0;
        cur_b         = '0;
        i_rst_n       = 1'b0;
        text_if.valid = 1'b0;
        text_if.data  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Nothing is in use after reset, so even the empty command is refused.
        send_command(bytes_of(""), 1'b0);
        settle();
        write_pattern(1'b0, pattern_of("ab*?", 5'd4));
        write_reg(CFG_A_LAST, '1);
        cur_a.last_chars = '1;
        write_pattern(1'b1, '{first_chars: '1, last_chars: '1, length: 5'd0});
        write_reg(CFG_IN_USE, 64'd2);
        send_command(bytes_of(""), 1'b0);
        send_command(bytes_of("abx"), 1'b0);
        send_command(bytes_of("ab"), 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        // An empty-marked transfer closes the command early and ignores its byte and last flag.
        send_command(bytes_of("abc"), 1'b1);
        send_item(8'h61, 1'b0, 1'b0);
        send_item(8'h62, 1'b0, 1'b0);
        settle();
        write_reg(CFG_A_LENGTH, 64'd2);
        cur_a.length = 5'd2;
        send_item(8'h00, 1'b1, 1'b1);
        settle();
        // Over-long length folds to the full sixteen bytes; an in-use value of three means both.
        write_pattern(1'b0, '{first_chars: {8{STAR_BYTE}}, last_chars: {8{STAR_BYTE}},
                              length: 5'd31});
        write_pattern(1'b1, '{first_chars: '0, last_chars: '0, length: 5'd16});
        write_reg(CFG_IN_USE, 64'd3);
        send_command(bytes_of("z"), 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_command(bytes_of("?*"), 1'b0);

        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            settle();
            random_settings();
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // The result side holds off while bytes keep coming, so the input backs up.
                tx_quiet = 1'b1;
                rx_quiet = 1'b0;
                hold_len = 150;
            end
            repeat (25) random_command();
            phase++;
        end

        text_idle(1);
        while (sb.verdicts.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.verdicts.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
